### rtl/core/ucs_pkg.sv
// URL component splitter: shared types, codes and widths.
// No dependencies; imported by every module of the splitter.
package ucs_pkg;

  localparam int unsigned UCS_MAX_URL_LEN = 1024;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned COMP_W  = 4;
  localparam int unsigned START_W = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned NUM_SEC = 9;
  localparam int unsigned SEC_W   = 4;
  localparam int unsigned ENTRY_W = START_W + LEN_W;
  localparam int unsigned DIGIT_W = PORT_W + 1;

  // Front-end phase while the optional scheme is being recognised.
  typedef enum logic [1:0] {
    PH_CAND,
    PH_COLON,
    PH_SLASH,
    PH_MAIN
  } ucs_phase_e;

  // Section of the URL; also the entry index of the range table.
  typedef enum logic [SEC_W-1:0] {
    SEC_SCHEME = 4'd0,
    SEC_USER   = 4'd1,
    SEC_PASS   = 4'd2,
    SEC_HOST   = 4'd3,
    SEC_PORT   = 4'd4,
    SEC_PATH   = 4'd5,
    SEC_PARAMS = 4'd6,
    SEC_QUERY  = 4'd7,
    SEC_FRAG   = 4'd8
  } ucs_sec_e;

  // Component codes on the result channel.
  localparam logic [COMP_W-1:0] COMP_SCHEME     = 4'd0;
  localparam logic [COMP_W-1:0] COMP_USER       = 4'd1;
  localparam logic [COMP_W-1:0] COMP_PASS       = 4'd2;
  localparam logic [COMP_W-1:0] COMP_HOST       = 4'd3;
  localparam logic [COMP_W-1:0] COMP_PORT       = 4'd4;
  localparam logic [COMP_W-1:0] COMP_PATH       = 4'd5;
  localparam logic [COMP_W-1:0] COMP_PARAMS     = 4'd6;
  localparam logic [COMP_W-1:0] COMP_QUERY      = 4'd7;
  localparam logic [COMP_W-1:0] COMP_FRAG       = 4'd8;
  localparam logic [COMP_W-1:0] COMP_PATH_QUERY = 4'd9;

  // Characters of interest.
  localparam logic [CH_W-1:0] CH_COLON = 8'h3a;
  localparam logic [CH_W-1:0] CH_AT    = 8'h40;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CH_W-1:0] CH_SEMI  = 8'h3b;
  localparam logic [CH_W-1:0] CH_QUEST = 8'h3f;
  localparam logic [CH_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_DEL   = 8'h7f;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  localparam logic [DIGIT_W-1:0] DIGIT_BAD = 17'h10000;

  // One range-table write.
  typedef struct packed {
    logic               en;
    ucs_sec_e           sec;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } ucs_wr_t;

  // Summary of a finished URL, handed to the result side.
  typedef struct packed {
    logic               ok;
    logic               saw_at;
    logic [PORT_W-1:0]  port;
    logic               fin_en;
    ucs_sec_e           fin_sec;
    logic [START_W-1:0] fin_start;
    logic [LEN_W-1:0]   fin_len;
  } ucs_job_t;

endpackage

### rtl/core/url_component_splitter.sv
// Top level of the URL component splitter: byte scanner plus table readout.
// Depends on ucs_pkg, ucs_scan and ucs_readout.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   ch_i, last_char_i
//  out      source     out_valid_o / out_stall_i component_o, start_res_o, length_o,
//                                                port_number_o, ok_o, last_result_o
//
// One input beat per cycle. Each beat is classified and the scanner state is
// updated in that cycle; a closed component range is written to the range
// table memory at once. The last beat of a URL hands a job to the readout,
// which drains the table at one entry per cycle through the registered memory
// read: ten result beats per URL, one for an error. The table has two banks,
// so the next URL fills one while the previous drains; a last beat is held
// off while the readout still issues reads or its read stage is occupied, so
// URLs of eleven bytes or more run at one byte per cycle. Reset is
// asynchronous and clears the entry valid flags at once: no clearing pass.
// out_stall_i holds the output register and the read stage; input beats keep
// flowing until a last beat needs the readout.
module url_component_splitter #(
  parameter int unsigned MAX_URL_LEN = ucs_pkg::UCS_MAX_URL_LEN
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ucs_pkg::CH_W-1:0]    ch_i,
  input  logic                        last_char_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [ucs_pkg::COMP_W-1:0]  component_o,
  output logic [ucs_pkg::START_W-1:0] start_res_o,
  output logic [ucs_pkg::LEN_W-1:0]   length_o,
  output logic [ucs_pkg::PORT_W-1:0]  port_number_o,
  output logic                        ok_o,
  output logic                        last_result_o
);
  import ucs_pkg::*;

  ucs_wr_t  wr;
  ucs_job_t job;
  logic     job_valid;
  logic     launch_ok;

  // Scanner: phase/section tracking, port digits, error detection.
  ucs_scan #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .last_char_i (last_char_i),
    .launch_ok_i (launch_ok),
    .wr_o        (wr),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // Readout: range table memory and the ten-beat result sequence.
  ucs_readout u_readout (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (wr),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .launch_ok_o   (launch_ok),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .component_o   (component_o),
    .start_res_o   (start_res_o),
    .length_o      (length_o),
    .port_number_o (port_number_o),
    .ok_o          (ok_o),
    .last_result_o (last_result_o)
  );

endmodule

### rtl/core/ucs_scan.sv
// Byte scanner: tracks phase and section of the URL, port digits and errors.
// Depends on ucs_pkg; issues range-table writes and a job per finished URL.
module ucs_scan #(
  parameter int unsigned MAX_URL_LEN = ucs_pkg::UCS_MAX_URL_LEN
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ucs_pkg::CH_W-1:0] ch_i,
  input  logic                     last_char_i,
  input  logic                     launch_ok_i,
  output ucs_pkg::ucs_wr_t         wr_o,
  output logic                     job_valid_o,
  output ucs_pkg::ucs_job_t        job_o
);
  import ucs_pkg::*;

  localparam int unsigned PW = $clog2(MAX_URL_LEN + 1);
  localparam logic [PW-1:0] MaxLen = PW'(MAX_URL_LEN);

  ucs_phase_e         phase_q, phase_d;
  ucs_sec_e           section_q, section_d;
  logic [PW-1:0]      position_q, position_d;
  logic [PW-1:0]      seg_q, seg_d;
  logic               saw_at_q, saw_at_d;
  logic               error_q, error_d;
  logic               frag_q, frag_d;
  logic [DIGIT_W-1:0] ppv_q, ppv_d;
  logic [DIGIT_W-1:0] pv_q, pv_d;

  logic               accept;
  logic               forbidden;
  logic               scheme_c;
  logic               sch_wr;
  logic               st_en;
  ucs_sec_e           st_sec;
  logic [PW-1:0]      st_seg;
  ucs_sec_e           fin_sec;
  logic [PW-1:0]      fin_seg;
  logic [DIGIT_W-1:0] pv_sel;

  function automatic logic [DIGIT_W-1:0] add_digit(logic [DIGIT_W-1:0] v,
                                                   logic [CH_W-1:0] c);
    logic [PORT_W-1:0] t;
    t = PORT_W'(v[PORT_W-1:0] << 3) + PORT_W'(v[PORT_W-1:0] << 1)
        + PORT_W'(c[3:0]);
    if (v[PORT_W]) begin
      return v;
    end else if (c < CH_ZERO || c > CH_NINE) begin
      return DIGIT_BAD;
    end
    return {1'b0, t};
  endfunction

  assign in_stall_o = last_char_i & ~launch_ok_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // Character classes.
  always_comb begin
    forbidden = (ch_i < CH_SPACE) || ch_i[7] || (ch_i == CH_DEL);
    unique case (ch_i)
      8'h20, 8'h22, 8'h3c, 8'h3e, 8'h5b, 8'h5c,
      8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d: forbidden = 1'b1;
      default: ;
    endcase
    scheme_c = (ch_i >= 8'h61 && ch_i <= 8'h7a) || (ch_i >= 8'h41 && ch_i <= 8'h5a) ||
               (ch_i >= CH_ZERO && ch_i <= CH_NINE) ||
               ch_i == 8'h2e || ch_i == 8'h2b || ch_i == 8'h2d;
  end

  // Next state of the scanner.
  always_comb begin
    logic          over;
    logic          pm_go;
    logic          col_err;
    ucs_sec_e      pm_sec;
    logic [PW-1:0] pm_seg;
    phase_d    = phase_q;
    section_d  = section_q;
    seg_d      = seg_q;
    saw_at_d   = saw_at_q;
    frag_d     = frag_q;
    ppv_d      = ppv_q;
    pv_d       = pv_q;
    over       = (position_q >= MaxLen);
    error_d    = error_q | over;
    position_d = over ? position_q : PW'(position_q + 1'b1);
    sch_wr     = 1'b0;
    st_en      = 1'b0;
    st_sec     = SEC_SCHEME;
    st_seg     = '0;
    pm_go      = 1'b0;
    col_err    = 1'b0;
    pm_sec     = section_q;
    pm_seg     = seg_q;

    if (!error_d && !frag_q) begin
      unique case (phase_q)
        PH_CAND: begin
          if (scheme_c) begin
            // stay a scheme candidate
          end else if (ch_i == CH_COLON) begin
            if (position_q == '0) begin
              error_d = 1'b1;
            end else begin
              sch_wr  = 1'b1;
              phase_d = PH_COLON;
            end
          end else if (ch_i == CH_SLASH && position_q == '0) begin
            phase_d = PH_SLASH;
            seg_d   = '0;
          end else begin
            phase_d = PH_MAIN;
            pm_go   = 1'b1;
            pm_sec  = SEC_PATH;
            pm_seg  = '0;
          end
        end
        PH_COLON: begin
          seg_d = position_q;
          if (ch_i == CH_SLASH) begin
            phase_d = PH_SLASH;
          end else begin
            phase_d = PH_MAIN;
            pm_go   = 1'b1;
            pm_sec  = SEC_PATH;
            pm_seg  = position_q;
          end
        end
        PH_SLASH: begin
          phase_d = PH_MAIN;
          if (ch_i == CH_SLASH) begin
            section_d = SEC_USER;
            seg_d     = PW'(position_q + 1'b1);
          end else begin
            pm_go  = 1'b1;
            pm_sec = SEC_PATH;
            pm_seg = seg_q;
          end
        end
        PH_MAIN: begin
          pm_go = 1'b1;
        end
        default: ;
      endcase
    end

    if (pm_go) begin
      section_d = pm_sec;
      seg_d     = pm_seg;
      st_seg    = pm_seg;
      st_sec    = pm_sec;
      if (forbidden) begin
        error_d = 1'b1;
      end else begin
        unique case (ch_i)
          CH_COLON: begin
            if (pm_sec == SEC_USER || pm_sec == SEC_HOST) begin
              st_en     = 1'b1;
              seg_d     = PW'(position_q + 1'b1);
              section_d = (pm_sec == SEC_USER) ? SEC_PASS : SEC_PORT;
            end else if (pm_sec == SEC_PASS || pm_sec == SEC_PORT) begin
              error_d = 1'b1;
              col_err = 1'b1;
            end
          end
          CH_AT: begin
            if (pm_sec == SEC_USER || pm_sec == SEC_PASS) begin
              saw_at_d  = 1'b1;
              st_en     = 1'b1;
              seg_d     = PW'(position_q + 1'b1);
              section_d = SEC_HOST;
            end
          end
          CH_SLASH: begin
            if (pm_sec == SEC_USER || pm_sec == SEC_PASS ||
                pm_sec == SEC_HOST || pm_sec == SEC_PORT) begin
              // a slash straight after the user part closes a host
              if (pm_sec == SEC_USER) begin
                saw_at_d = 1'b1;
                st_sec   = SEC_HOST;
              end
              st_en     = 1'b1;
              seg_d     = position_q;
              section_d = SEC_PATH;
            end
          end
          CH_SEMI: begin
            if (pm_sec == SEC_PATH) begin
              st_en     = 1'b1;
              seg_d     = PW'(position_q + 1'b1);
              section_d = SEC_PARAMS;
            end
          end
          CH_QUEST: begin
            if (pm_sec == SEC_PATH || pm_sec == SEC_PARAMS) begin
              st_en     = 1'b1;
              seg_d     = PW'(position_q + 1'b1);
              section_d = SEC_QUERY;
            end
          end
          CH_HASH: begin
            st_en     = 1'b1;
            seg_d     = PW'(position_q + 1'b1);
            section_d = SEC_FRAG;
            frag_d    = 1'b1;
          end
          default: ;
        endcase
        if (!col_err && section_d == pm_sec) begin
          if (pm_sec == SEC_PASS) begin
            ppv_d = add_digit(ppv_q, ch_i);
          end else if (pm_sec == SEC_PORT) begin
            pv_d = add_digit(pv_q, ch_i);
          end
        end
      end
    end
  end

  // Table write and job summary.
  always_comb begin
    logic [PW-1:0] fin_len_full;
    wr_o.en    = accept & (sch_wr | (st_en & (position_q > st_seg)));
    wr_o.sec   = sch_wr ? SEC_SCHEME : st_sec;
    wr_o.start = sch_wr ? '0 : START_W'(st_seg);
    wr_o.len   = sch_wr ? LEN_W'(position_q) : LEN_W'(position_q - st_seg);

    unique case (phase_d)
      PH_CAND: begin
        fin_sec = SEC_PATH;
        fin_seg = '0;
      end
      PH_COLON: begin
        fin_sec = SEC_PATH;
        fin_seg = position_d;
      end
      PH_SLASH: begin
        fin_sec = SEC_PATH;
        fin_seg = seg_d;
      end
      default: begin
        fin_sec = section_d;
        fin_seg = seg_d;
      end
    endcase
    fin_len_full = position_d - fin_seg;
    pv_sel       = saw_at_d ? pv_d : ppv_d;

    job_valid_o       = accept & last_char_i;
    job_o.ok          = ~error_d;
    job_o.saw_at      = saw_at_d;
    job_o.port        = pv_sel[PORT_W] ? '0 : pv_sel[PORT_W-1:0];
    job_o.fin_en      = position_d > fin_seg;
    job_o.fin_sec     = fin_sec;
    job_o.fin_start   = START_W'(fin_seg);
    job_o.fin_len     = LEN_W'(fin_len_full);
  end

  // Advance on every beat; return to the idle URL state after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CAND;
      section_q  <= SEC_SCHEME;
      position_q <= '0;
      seg_q      <= '0;
      saw_at_q   <= 1'b0;
      error_q    <= 1'b0;
      frag_q     <= 1'b0;
      ppv_q      <= '0;
      pv_q       <= '0;
    end else if (accept) begin
      if (last_char_i) begin
        phase_q    <= PH_CAND;
        section_q  <= SEC_SCHEME;
        position_q <= '0;
        seg_q      <= '0;
        saw_at_q   <= 1'b0;
        error_q    <= 1'b0;
        frag_q     <= 1'b0;
        ppv_q      <= '0;
        pv_q       <= '0;
      end else begin
        phase_q    <= phase_d;
        section_q  <= section_d;
        position_q <= position_d;
        seg_q      <= seg_d;
        saw_at_q   <= saw_at_d;
        error_q    <= error_d;
        frag_q     <= frag_d;
        ppv_q      <= ppv_d;
        pv_q       <= pv_d;
      end
    end
  end

endmodule

### rtl/core/ucs_readout.sv
// Range-table memory (two banks) and result sequencer.
// Depends on ucs_pkg; fed by ucs_scan with table writes and finished jobs.
module ucs_readout (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ucs_pkg::ucs_wr_t              wr_i,
  input  logic                          job_valid_i,
  input  ucs_pkg::ucs_job_t             job_i,
  output logic                          launch_ok_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ucs_pkg::COMP_W-1:0]    component_o,
  output logic [ucs_pkg::START_W-1:0]   start_res_o,
  output logic [ucs_pkg::LEN_W-1:0]     length_o,
  output logic [ucs_pkg::PORT_W-1:0]    port_number_o,
  output logic                          ok_o,
  output logic                          last_result_o
);
  import ucs_pkg::*;

  // Table storage: one bank fills while the other drains.
  logic [ENTRY_W-1:0] mem_q [2][NUM_SEC];
  logic [ENTRY_W-1:0] rdata_q;

  logic               wr_bank_q, rd_bank_q;
  logic [NUM_SEC-1:0] vld_q, vld_d, snap_q;
  ucs_job_t           job_q;

  logic               rd_busy_q, rd_busy_d;
  logic [COMP_W-1:0]  k_q;
  logic               s1_valid_q;
  logic [COMP_W-1:0]  s1_k_q;
  logic               out_valid_q;

  logic [LEN_W-1:0]   pq_len_q;
  logic [START_W-1:0] path_start_q;
  logic               path_hit_q;

  logic               out_free, s1_adv, issue, launch;
  ucs_sec_e           rd_idx, s1_idx;
  logic               eff_pr;
  logic [START_W-1:0] eff_start;
  logic [LEN_W-1:0]   eff_len;
  logic               s1_last;

  function automatic ucs_sec_e comp_to_idx(logic [COMP_W-1:0] k, logic saw);
    ucs_sec_e idx;
    unique case (k)
      COMP_SCHEME: idx = SEC_SCHEME;
      COMP_USER:   idx = SEC_USER;
      COMP_PASS:   idx = SEC_PASS;
      COMP_HOST:   idx = saw ? SEC_HOST : SEC_USER;
      COMP_PORT:   idx = saw ? SEC_PORT : SEC_PASS;
      COMP_PARAMS: idx = SEC_PARAMS;
      COMP_QUERY:  idx = SEC_QUERY;
      COMP_FRAG:   idx = SEC_FRAG;
      default:     idx = SEC_PATH;
    endcase
    return idx;
  endfunction

  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign s1_adv      = s1_valid_q & out_free;
  assign issue       = rd_busy_q & (~s1_valid_q | s1_adv);
  assign launch_ok_o = ~rd_busy_q & (~s1_valid_q | s1_adv);
  assign launch      = job_valid_i;
  assign rd_idx      = comp_to_idx(k_q, job_q.saw_at);
  assign s1_idx      = comp_to_idx(s1_k_q, job_q.saw_at);
  assign s1_last     = (s1_k_q == COMP_PATH_QUERY) | ~job_q.ok;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_bank_q][wr_i.sec] <= {wr_i.start, wr_i.len};
    end
    if (issue) begin
      rdata_q <= mem_q[rd_bank_q][rd_idx];
    end
  end

  // Entry valid flags of the filling bank; the drain side keeps a snapshot.
  always_comb begin
    vld_d = vld_q;
    if (wr_i.en) begin
      vld_d[wr_i.sec] = 1'b1;
    end
  end

  always_comb begin
    rd_busy_d = rd_busy_q;
    if (issue && (k_q == COMP_PATH_QUERY || !job_q.ok)) begin
      rd_busy_d = 1'b0;
    end
    if (launch) begin
      rd_busy_d = 1'b1;
    end
  end

  // Effective entry: the closing range of the URL overrides the table.
  always_comb begin
    if (job_q.fin_en && job_q.fin_sec == s1_idx) begin
      eff_pr    = 1'b1;
      eff_start = job_q.fin_start;
      eff_len   = job_q.fin_len;
    end else if (snap_q[s1_idx]) begin
      eff_pr    = 1'b1;
      eff_start = rdata_q[ENTRY_W-1:LEN_W];
      eff_len   = rdata_q[LEN_W-1:0];
    end else begin
      eff_pr    = 1'b0;
      eff_start = '0;
      eff_len   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_bank_q   <= 1'b0;
      rd_bank_q   <= 1'b0;
      vld_q       <= '0;
      snap_q      <= '0;
      rd_busy_q   <= 1'b0;
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      path_hit_q  <= 1'b0;
      job_q       <= '0;
    end else begin
      rd_busy_q <= rd_busy_d;
      if (launch) begin
        snap_q    <= vld_d;
        vld_q     <= '0;
        job_q     <= job_i;
        rd_bank_q <= wr_bank_q;
        wr_bank_q <= ~wr_bank_q;
        k_q       <= '0;
      end else begin
        vld_q <= vld_d;
        if (issue) begin
          k_q <= k_q + 1'b1;
        end
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (launch) begin
        path_hit_q <= 1'b0;
      end else if (s1_adv && s1_k_q == COMP_PATH) begin
        path_hit_q <= eff_pr;
      end
    end
  end

  // Data path: read stage tag, path-plus-query sum and output register.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_k_q <= k_q;
    end
    if (launch) begin
      pq_len_q <= '0;
    end else if (s1_adv) begin
      if (s1_k_q == COMP_PATH) begin
        pq_len_q     <= eff_len;
        path_start_q <= eff_start;
      end else if ((s1_k_q == COMP_PARAMS || s1_k_q == COMP_QUERY) &&
                   eff_pr && path_hit_q) begin
        pq_len_q <= pq_len_q + eff_len + LEN_W'(1);
      end
    end
    if (s1_adv) begin
      last_result_o <= s1_last;
      ok_o          <= job_q.ok;
      port_number_o <= job_q.ok ? job_q.port : '0;
      if (!job_q.ok) begin
        component_o <= COMP_SCHEME;
        start_res_o <= '0;
        length_o    <= '0;
      end else if (s1_k_q == COMP_PATH_QUERY) begin
        component_o <= COMP_PATH_QUERY;
        start_res_o <= path_hit_q ? path_start_q : '0;
        length_o    <= path_hit_q ? pq_len_q : '0;
      end else if (!job_q.saw_at && (s1_k_q == COMP_USER || s1_k_q == COMP_PASS)) begin
        component_o <= s1_k_q;
        start_res_o <= '0;
        length_o    <= '0;
      end else begin
        component_o <= s1_k_q;
        start_res_o <= eff_start;
        length_o    <= eff_len;
      end
    end
  end

endmodule
